// File: src/assert_macros.svh
// Assertion helpers used by the filter core (mfrf_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_ON_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mfrf_pkg.sv
package mfrf_pkg;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_ACCEPT   = 2'd0,
        VERDICT_REJECT   = 2'd1,
        VERDICT_ACK_SEEN = 2'd2,
        VERDICT_LEN_ERR  = 2'd3
    } t_verdict;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_PAN        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_SHORT_ADDR = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_LONG_ADDR  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROMISCUOUS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_ACK       = 3'd4;
    localparam int CFG_DATA_W = 64;

    // Frame control codes
    localparam logic [2:0] FRAME_KIND_DATA = 3'd1;
    localparam logic [2:0] FRAME_KIND_ACK  = 3'd2;
    localparam logic [1:0] DST_MODE_SHORT  = 2'd2;
    localparam logic [1:0] DST_MODE_LONG   = 2'd3;

    // Minimum lengths for the header fields to be present
    localparam logic [7:0] MIN_LEN_SEQ   = 8'd3;
    localparam logic [7:0] MIN_LEN_SHORT = 8'd7;
    localparam logic [7:0] MIN_LEN_LONG  = 8'd13;

    localparam logic [15:0] BCAST_ID    = 16'hffff;
    localparam logic [8:0]  RSSI_OFFSET = 9'd77;
    localparam logic [8:0]  LQI_BASE    = 9'd296;
    localparam logic [7:0]  LQI_MAX     = 8'd255;
    localparam logic [8:0]  NO_ACK_SEQ  = 9'h1ff;

    typedef struct packed {
        logic [15:0] own_pan;
        logic [31:0] own_short_addr;
        logic [63:0] own_long_addr;
        logic        promiscuous;
        logic        auto_ack;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        verdict;
        logic              ack_needed;
        logic [7:0]        seq_number;
        logic [7:0]        frame_len;
        logic              crc_good;
        logic signed [8:0] rssi_dbm;
        logic [7:0]        link_quality;
        logic signed [8:0] last_ack_seq;
    } t_result;

endpackage

// File: src/mfrf_if.sv
interface mfrf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfrf_res_if;
    logic              valid;
    logic              ready;
    logic [1:0]        verdict;
    logic              ack_needed;
    logic [7:0]        seq_number;
    logic [7:0]        frame_len;
    logic              crc_good;
    logic signed [8:0] rssi_dbm;
    logic [7:0]        link_quality;
    logic signed [8:0] last_ack_seq;

    modport source (output valid, output verdict, output ack_needed, output seq_number,
                    output frame_len, output crc_good, output rssi_dbm,
                    output link_quality, output last_ack_seq, input ready);
    modport sink (input valid, input verdict, input ack_needed, input seq_number,
                  input frame_len, input crc_good, input rssi_dbm,
                  input link_quality, input last_ack_seq, output ready);
endinterface

interface mfrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [63:0] wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

// File: src/mfrf_cfg_regs.sv
module mfrf_cfg_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_valid,
    input  logic [mfrf_pkg::CFG_ADDR_W-1:0]       i_wr_addr,
    input  logic [mfrf_pkg::CFG_DATA_W-1:0]       i_wr_data,
    output logic                                  o_wr_ready,
    output mfrf_pkg::t_cfg                        o_cfg
);
    import mfrf_pkg::*;

    t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_valid) begin
            case (i_wr_addr)
                CFG_OWN_PAN:        r_cfg.own_pan        <= i_wr_data[15:0];
                CFG_OWN_SHORT_ADDR: r_cfg.own_short_addr <= i_wr_data[31:0];
                CFG_OWN_LONG_ADDR:  r_cfg.own_long_addr  <= i_wr_data;
                CFG_PROMISCUOUS:    r_cfg.promiscuous    <= i_wr_data[0];
                CFG_AUTO_ACK:       r_cfg.auto_ack       <= i_wr_data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

endmodule

// File: src/mfrf_core.sv
`include "assert_macros.svh"

module mfrf_core #(
    parameter int MAX_FRAME_LEN = 127
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_in_byte,
    output logic              o_in_ready,
    input  mfrf_pkg::t_cfg    i_cfg,
    input  logic              i_res_space,
    output logic              o_res_valid,
    output mfrf_pkg::t_result o_res
);
    import mfrf_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_BODY,
        PH_RSSI,
        PH_STATUS
    } t_phase;

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

    // input register
    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_in_byte, n_in_byte;
    // frame state
    t_phase            r_phase, n_phase;
    logic [7:0]        r_byte_count, n_byte_count;
    logic [7:0]        r_frame_length, n_frame_length;
    logic [15:0]       r_frame_control, n_frame_control;
    logic [7:0]        r_seq_byte, n_seq_byte;
    logic [15:0]       r_dest_pan, n_dest_pan;
    logic [63:0]       r_dest_addr, n_dest_addr;
    logic [7:0]        r_rssi_raw, n_rssi_raw;
    logic [8:0]        r_last_ack, n_last_ack;

    logic              advance;
    logic              b_crc;
    logic [2:0]        f_type;
    logic [1:0]        f_mode;
    logic              short_hit;
    logic              long_hit;
    logic [8:0]        rssi_half;
    logic [8:0]        lqi_raw;
    logic [8:0]        count_inc;
    t_verdict          verdict;
    logic              ack_req;

    assign advance    = r_in_valid && i_res_space;
    assign o_in_ready = !r_in_valid || advance;

    // judgement terms, from the status byte in the input register and the captured header fields
    assign b_crc  = r_in_byte[7];
    assign f_type = r_frame_control[2:0];
    assign f_mode = r_frame_control[11:10];
    assign short_hit = (r_dest_pan == BCAST_ID && r_dest_addr[15:0] == BCAST_ID) ||
                       (r_dest_pan == i_cfg.own_pan &&
                        (r_dest_addr[15:0] == BCAST_ID ||
                         {16'd0, r_dest_addr[15:0]} == i_cfg.own_short_addr));
    assign long_hit  = r_dest_pan == i_cfg.own_pan && r_dest_addr == i_cfg.own_long_addr;

    // halve toward zero: add one to negative values before the shift
    assign rssi_half = 9'($signed({r_rssi_raw[7], r_rssi_raw} + {8'd0, r_rssi_raw[7]}) >>> 1);
    assign lqi_raw   = LQI_BASE - {1'b0, r_in_byte[6:0], 1'b0};
    assign count_inc = {1'b0, r_byte_count} + 9'd1;

    always_comb begin
        verdict = VERDICT_REJECT;
        ack_req = 1'b0;
        if (i_cfg.promiscuous) begin
            verdict = VERDICT_ACCEPT;
        end else if (b_crc && r_frame_length >= MIN_LEN_SEQ) begin
            if (f_type == FRAME_KIND_ACK) begin
                verdict = VERDICT_ACK_SEEN;
            end else if (f_type == FRAME_KIND_DATA) begin
                if ((f_mode == DST_MODE_SHORT && r_frame_length >= MIN_LEN_SHORT && short_hit) ||
                    (f_mode == DST_MODE_LONG && r_frame_length >= MIN_LEN_LONG && long_hit)) begin
                    verdict = VERDICT_ACCEPT;
                    ack_req = r_frame_control[5] && i_cfg.auto_ack;
                end
            end
        end
    end

    always_comb begin
        n_in_valid      = r_in_valid;
        n_in_byte       = r_in_byte;
        n_phase         = r_phase;
        n_byte_count    = r_byte_count;
        n_frame_length  = r_frame_length;
        n_frame_control = r_frame_control;
        n_seq_byte      = r_seq_byte;
        n_dest_pan      = r_dest_pan;
        n_dest_addr     = r_dest_addr;
        n_rssi_raw      = r_rssi_raw;
        n_last_ack      = r_last_ack;
        o_res_valid     = 1'b0;
        o_res           = '0;
        o_res.last_ack_seq = r_last_ack;

        if (advance) begin
            case (r_phase)
                PH_LEN: begin
                    if (r_in_byte > MaxLen) begin
                        o_res_valid   = 1'b1;
                        o_res.verdict = VERDICT_LEN_ERR;
                        o_res.frame_len = r_in_byte;
                    end else begin
                        n_frame_length  = r_in_byte;
                        n_byte_count    = '0;
                        n_frame_control = '0;
                        n_seq_byte      = '0;
                        n_dest_pan      = '0;
                        n_dest_addr     = '0;
                        n_rssi_raw      = '0;
                        n_phase         = (r_in_byte == 8'd0) ? PH_RSSI : PH_BODY;
                    end
                end
                PH_BODY: begin
                    case (r_byte_count) inside
                        8'd0: n_frame_control[7:0]  = r_in_byte;
                        8'd1: n_frame_control[15:8] = r_in_byte;
                        8'd2: n_seq_byte            = r_in_byte;
                        8'd3: n_dest_pan[7:0]       = r_in_byte;
                        8'd4: n_dest_pan[15:8]      = r_in_byte;
                        [8'd5:8'd12]: begin
                            for (int k = 0; k < 8; k++) begin
                                if (r_byte_count == 8'(5 + k)) begin
                                    n_dest_addr[k*8 +: 8] = r_in_byte;
                                end
                            end
                        end
                        default: ;  // payload bytes past the header
                    endcase
                    n_byte_count = count_inc[7:0];
                    if (count_inc >= {1'b0, r_frame_length}) begin
                        n_phase = PH_RSSI;
                    end
                end
                PH_RSSI: begin
                    n_rssi_raw = r_in_byte;
                    n_phase    = PH_STATUS;
                end
                PH_STATUS: begin
                    if (verdict == VERDICT_ACK_SEEN) begin
                        n_last_ack = {1'b0, r_seq_byte};
                    end
                    o_res_valid        = 1'b1;
                    o_res.verdict      = verdict;
                    o_res.ack_needed   = ack_req;
                    o_res.seq_number   = r_seq_byte;
                    o_res.frame_len    = r_frame_length;
                    o_res.crc_good     = b_crc;
                    o_res.rssi_dbm     = $signed(rssi_half - RSSI_OFFSET);
                    o_res.link_quality = lqi_raw[8] ? LQI_MAX : lqi_raw[7:0];
                    o_res.last_ack_seq = $signed((verdict == VERDICT_ACK_SEEN) ?
                                                 {1'b0, r_seq_byte} : r_last_ack);
                    n_phase            = PH_LEN;
                end
                default: n_phase = PH_LEN;
            endcase
        end

        if (o_in_ready) begin
            n_in_valid = i_in_valid;
            n_in_byte  = i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_in_byte       <= '0;
            r_phase         <= PH_LEN;
            r_byte_count    <= '0;
            r_frame_length  <= '0;
            r_frame_control <= '0;
            r_seq_byte      <= '0;
            r_dest_pan      <= '0;
            r_dest_addr     <= '0;
            r_rssi_raw      <= '0;
            r_last_ack      <= NO_ACK_SEQ;
        end else begin
            r_in_valid      <= n_in_valid;
            r_in_byte       <= n_in_byte;
            r_phase         <= n_phase;
            r_byte_count    <= n_byte_count;
            r_frame_length  <= n_frame_length;
            r_frame_control <= n_frame_control;
            r_seq_byte      <= n_seq_byte;
            r_dest_pan      <= n_dest_pan;
            r_dest_addr     <= n_dest_addr;
            r_rssi_raw      <= n_rssi_raw;
            r_last_ack      <= n_last_ack;
        end
    end

    // a result only comes from a status word or an oversize length word
    `ASSERT_ON_RUN(a_res_source, i_clk, i_rst_n,
        o_res_valid |-> (r_phase == PH_STATUS || (r_phase == PH_LEN && r_in_byte > MaxLen)),
        "result outside status or length-error word")
    // last ACK changes only when an ACK frame is judged
    `ASSERT_ON_RUN(a_last_ack_src, i_clk, i_rst_n,
        (r_last_ack != $past(r_last_ack)) |-> $past(o_res_valid && verdict == VERDICT_ACK_SEEN),
        "last ACK changed without an ACK verdict")
    // byte count never runs past the frame length
    `ASSERT_ON_RUN(a_count_bound, i_clk, i_rst_n,
        (r_phase == PH_BODY) |-> (r_byte_count < r_frame_length),
        "body byte count past frame length")

endmodule

// File: src/mfrf_out_queue.sv
module mfrf_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mfrf_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output mfrf_pkg::t_result o_data
);
    import mfrf_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_space = r_cnt != 2'd2;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (pop)    r_rd_ptr <= !r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// File: src/mac_frame_rx_filter.sv
// Receive address filter for an 802.15.4 style radio.
// i_rx: one received word per transfer (length, frame bytes, RSSI, status).
// o_res: one verdict word per frame, given once the status word is judged,
//   plus one word for every length above MAX_FRAME_LEN (length error).
// i_cfg: register writes (own PAN, short and long address, promiscuous,
//   auto-ack); always ready, to be used while the block is idle.
// Path: a taken word lands in the input register, is judged there once the
//   result queue has space and is then written into the two-entry result
//   queue, whose head word shows on o_res.
// Throughput: one word per cycle while the result queue has space, with the single
//   judgement stage between the input register and the result queue.
// Receiver stall: the result queue absorbs up to two words; once it is
//   full the input register holds and i_rx.ready drops until o_res drains.
// Reset: synchronous, active low; registers bar the result queue storage clear to zero,
//   the last ACK sequence to -1, and the filter waits for a length word.
module mac_frame_rx_filter #(
    parameter int MAX_FRAME_LEN = 127
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfrf_rx_if.sink    i_rx,
    mfrf_res_if.source o_res,
    mfrf_cfg_if.sink   i_cfg
);
    import mfrf_pkg::*;

    t_cfg    cfg;
    logic    res_space;
    logic    res_push;
    t_result res_word;
    t_result head;

    // register file
    mfrf_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_addr  (i_cfg.addr),
        .i_wr_data  (i_cfg.wdata),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    // input register, field capture and frame judgement
    mfrf_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_in_byte   (i_rx.rx_byte),
        .o_in_ready  (i_rx.ready),
        .i_cfg       (cfg),
        .i_res_space (res_space),
        .o_res_valid (res_push),
        .o_res       (res_word)
    );

    // result register with skid entry
    mfrf_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_word),
        .o_space (res_space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (head)
    );

    assign o_res.verdict      = head.verdict;
    assign o_res.ack_needed   = head.ack_needed;
    assign o_res.seq_number   = head.seq_number;
    assign o_res.frame_len    = head.frame_len;
    assign o_res.crc_good     = head.crc_good;
    assign o_res.rssi_dbm     = head.rssi_dbm;
    assign o_res.link_quality = head.link_quality;
    assign o_res.last_ack_seq = head.last_ack_seq;

endmodule
